/* design/arxh_pkg.sv */
// Package: shared types, constants and helpers for the ARX string hash.
`timescale 1ns / 1ps

package arxh_pkg;

    localparam logic [63:0] INIT_W0   = 64'h6d6574615f6d6172;
    localparam logic [63:0] INIT_W1   = 64'h7465735f7169735f;
    localparam logic [63:0] INIT_W2   = 64'h6e69755f4d654f6d;
    localparam logic [63:0] INIT_W3   = 64'h646f6d5f656e6f6d;
    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [63:0] FINAL_KEY = 64'hFEDCBA9876543210;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // One unit of work for the mix engine: a full block, or a tail block plus count.
    typedef struct packed {
        logic        fin;
        logic [63:0] len;
        logic [63:0] blk;
    } t_job;

    function automatic logic [63:0] rotl13(input logic [63:0] v);
        rotl13 = {v[50:0], v[63:51]};
    endfunction

    function automatic logic [63:0] rotl16(input logic [63:0] v);
        rotl16 = {v[47:0], v[63:48]};
    endfunction

    function automatic logic [63:0] rotl17(input logic [63:0] v);
        rotl17 = {v[46:0], v[63:47]};
    endfunction

    function automatic logic [63:0] rotl21(input logic [63:0] v);
        rotl21 = {v[42:0], v[63:43]};
    endfunction

endpackage

/* design/arxh_front.sv */
// Front end: byte buffering, block assembly, tail padding and byte count.
`timescale 1ns / 1ps

module arxh_front
    import arxh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_full
);

    logic [55:0] r_part;
    logic [2:0]  r_fill;
    logic [63:0] r_len;
    logic        w_accept;
    logic [63:0] w_tail;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // Tail: buffered bytes, pad byte at the fill position, count low byte on top.
    always_comb begin
        w_tail = '0;
        for (int j = 0; j < 7; j++) begin
            if (3'(j) < r_fill) begin
                w_tail[8*j +: 8] = r_part[8*j +: 8];
            end else if (3'(j) == r_fill) begin
                w_tail[8*j +: 8] = PAD_BYTE;
            end
        end
        w_tail[63:56] = r_len[7:0];
    end

    always_comb begin
        o_push = w_accept && ((i_item.operation == OP_FINISH) || (r_fill == 3'd7));
        o_job.fin = (i_item.operation == OP_FINISH);
        o_job.len = r_len;
        o_job.blk = (i_item.operation == OP_FINISH) ? w_tail
                                                    : {i_item.data_byte, r_part};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
        end else if (w_accept) begin
            if (i_item.operation == OP_FINISH) begin
                r_fill <= '0;
                r_len  <= '0;
            end else begin
                r_fill <= r_fill + 3'd1;
                r_len  <= r_len + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.operation == OP_ABSORB) && (r_fill != 3'd7)) begin
            r_part[8*r_fill +: 8] <= i_item.data_byte;
        end
    end

endmodule

/* design/arxh_queue.sv */
// Short job queue between the front end and the mix engine.
`timescale 1ns / 1ps

module arxh_queue
    import arxh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + (QUEUE_AW)'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + (QUEUE_AW)'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

/* design/arxh_back.sv */
// Mix engine: chain words, half-round steps, finalization and digest output.
`timescale 1ns / 1ps

module arxh_back
    import arxh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MIX  = 2'd1;
    localparam logic [1:0] S_NEXT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  r_phase;
    logic [1:0]  r_idx;
    logic        r_fin;
    logic        r_first;
    logic [63:0] r_blk;
    logic [63:0] r_len;
    logic [63:0] r_w [4];

    logic [63:0] n_a, n_b, n_c, n_d;
    logic [63:0] w_sel;

    assign w_sel = r_w[r_idx];
    assign o_pop = (r_state == S_IDLE) && i_job_valid;

    assign o_valid            = (r_state == S_OUT);
    assign o_item.digest_word = w_sel;
    assign o_item.word_index  = r_idx;
    assign o_item.last_word   = (r_idx == 2'd3);

    // Two independent half-steps per cycle; a round takes two phases.
    always_comb begin
        if (!r_phase[0]) begin
            n_a = r_w[0] + r_w[1];
            n_b = rotl13(r_w[1]) ^ n_a;
            n_c = r_w[2] + r_w[3];
            n_d = rotl16(r_w[3]) ^ n_c;
        end else begin
            n_a = r_w[0] + r_w[3];
            n_d = rotl21(r_w[3]) ^ n_a;
            n_c = r_w[2] + r_w[1];
            n_b = rotl17(r_w[1]) ^ n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_w[0]  <= INIT_W0;
            r_w[1]  <= INIT_W1;
            r_w[2]  <= INIT_W2;
            r_w[3]  <= INIT_W3;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_fin   <= i_job.fin;
                        r_first <= i_job.fin;
                        r_w[0]  <= r_w[0] ^ i_job.blk;
                        r_phase <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_w[1]  <= n_b;
                    r_w[2]  <= n_c;
                    r_w[3]  <= n_d;
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == 2'd3) begin
                        // Post-xor of the block; count folds in after the tail block.
                        r_w[0] <= n_a ^ r_blk ^ (r_first ? r_len : 64'd0);
                        if (!r_fin) begin
                            r_state <= S_IDLE;
                        end else if (r_first) begin
                            r_first <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_NEXT;
                        end else if (r_idx == 2'd3) begin
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_w[0] <= n_a;
                    end
                end
                S_NEXT: begin
                    r_w[0]  <= r_w[0] ^ w_sel ^ FINAL_KEY;
                    r_phase <= '0;
                    r_state <= S_MIX;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_idx == 2'd3) begin
                            r_idx   <= '0;
                            r_w[0]  <= INIT_W0;
                            r_w[1]  <= INIT_W1;
                            r_w[2]  <= INIT_W2;
                            r_w[3]  <= INIT_W3;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Block and count registers: job block and count on pop, finalization key block on each extra mix.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blk <= i_job.blk;
            r_len <= i_job.len;
        end else if (r_state == S_NEXT) begin
            r_blk <= w_sel ^ FINAL_KEY;
        end
    end

endmodule

/* design/arx_string_hash_256.sv */
// Top level: 256-bit ARX string hash, byte-serial front end and block mix engine.
// Throughput: one absorb item per cycle while the job queue has room; a full block
//   costs the engine a dequeue plus four half-round steps, so it keeps up with the bytes.
// Finish: with the engine idle, the first digest word waits for the tail mix and four
//   key mixes (key load plus four half-round steps), then 1 word/cycle while ready.
// Reset: synchronous active-low; loads the chain words, clears count, fill and queue.
`timescale 1ns / 1ps

module arx_string_hash_256
    import arxh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // Input items: absorb a byte or finish the message
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_in_item,
    // Result items: four digest words per finish
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out_item
);

    // Front end to queue
    logic q_push;
    t_job q_in_job;
    logic q_full;

    // Queue to mix engine
    logic q_valid;
    logic q_pop;
    t_job q_out_job;

    // The front end only pushes to the queue when a block completes or on finish,
    // but it drops ready for every item, plain bytes too, while the queue is full.
    arxh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_in_item),
        .o_push  (q_push),
        .o_job   (q_in_job),
        .i_full  (q_full)
    );

    // Decouples byte intake from the multi-cycle mixes and the digest drain.
    arxh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_out_job)
    );

    // Output payload comes straight from the chain registers, so a stalled
    // consumer holds only the engine while the front keeps taking bytes until the queue fills.
    arxh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_out_item)
    );

endmodule

/* verif/tb_arx_string_hash_256.sv */
// Testbench for arx_string_hash_256: directed and random messages, digests checked word by word.
`timescale 1ns / 1ps

// Tracks the hash state of the message stream and holds the digest words still due.
class digest_board;
    logic [63:0]          chain_w [4];
    logic [7:0]           held_byte [7];
    int unsigned          n_held;
    logic [63:0]          byte_total;
    arxh_pkg::t_out_item  pending_words [$];
    int unsigned          n_fail;

    function new();
        n_fail = 0;
        foreach (held_byte[i]) held_byte[i] = 8'h00;
        restart();
    endfunction

    function void restart();
        chain_w[0] = arxh_pkg::INIT_W0;
        chain_w[1] = arxh_pkg::INIT_W1;
        chain_w[2] = arxh_pkg::INIT_W2;
        chain_w[3] = arxh_pkg::INIT_W3;
        n_held     = 0;
        byte_total = 64'd0;
    endfunction

    function logic [63:0] rol(input logic [63:0] v, input int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    // Two ARX rounds, block xored into word 0 before and after.
    function void mix(input logic [63:0] blk);
        logic [63:0] a, b, c, d;
        a = chain_w[0] ^ blk;
        b = chain_w[1];
        c = chain_w[2];
        d = chain_w[3];
        for (int r = 0; r < 2; r++) begin
            a = a + b; b = rol(b, 13) ^ a;
            c = c + d; d = rol(d, 16) ^ c;
            a = a + d; d = rol(d, 21) ^ a;
            c = c + b; b = rol(b, 17) ^ c;
        end
        chain_w[0] = a ^ blk;
        chain_w[1] = b;
        chain_w[2] = c;
        chain_w[3] = d;
    endfunction

    function void take_input(input arxh_pkg::t_in_item it);
        logic [63:0]         blk;
        arxh_pkg::t_out_item w;
        blk = 64'd0;
        if (it.operation == arxh_pkg::OP_ABSORB) begin
            byte_total = byte_total + 64'd1;
            if (n_held < 7) begin
                held_byte[n_held] = it.data_byte;
                n_held++;
            end else begin
                for (int i = 0; i < 7; i++) blk[8*i +: 8] = held_byte[i];
                blk[63:56] = it.data_byte;
                mix(blk);
                n_held = 0;
            end
        end else begin
            // tail: buffered bytes, pad marker, count low byte on top (may overwrite pad)
            for (int i = 0; i < n_held; i++) blk[8*i +: 8] = held_byte[i];
            blk[8*n_held +: 8] = arxh_pkg::PAD_BYTE;
            blk[63:56] = byte_total[7:0];
            mix(blk);
            chain_w[0] = chain_w[0] ^ byte_total;
            for (int i = 0; i < 4; i++) mix(chain_w[i] ^ arxh_pkg::FINAL_KEY);
            for (int i = 0; i < 4; i++) begin
                w.digest_word = chain_w[i];
                w.word_index  = 2'(i);
                w.last_word   = (i == 3);
                pending_words.push_back(w);
            end
            restart();
        end
    endfunction

    task report_miss(input string what);
        n_fail++;
        if (n_fail <= 40) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_word(input arxh_pkg::t_out_item got);
        arxh_pkg::t_out_item want;
        if (pending_words.size() == 0) begin
            report_miss($sformatf("unexpected word %h idx %0d last %0b",
                                  got.digest_word, got.word_index, got.last_word));
            return;
        end
        want = pending_words.pop_front();
        if (got.digest_word !== want.digest_word)
            report_miss($sformatf("digest_word idx %0d: got %h want %h",
                                  want.word_index, got.digest_word, want.digest_word));
        if (got.word_index !== want.word_index)
            report_miss($sformatf("word_index: got %0d want %0d",
                                  got.word_index, want.word_index));
        if (got.last_word !== want.last_word)
            report_miss($sformatf("last_word idx %0d: got %0b want %0b",
                                  want.word_index, got.last_word, want.last_word));
    endtask

    function int outstanding();
        return pending_words.size();
    endfunction
endclass

module tb_arx_string_hash_256;
    import arxh_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_in_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_out_item;

    // calm: no idling on either side; flood_on: asks the receiver for one long hold-off
    bit        calm;
    bit        flood_on;

    digest_board board;

    arx_string_hash_256 u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_item  (i_in_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_item (o_out_item)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Offer one item from the falling edge; returns at the falling edge after it is taken.
    // Valid stays high on return so back-to-back items in calm mode never drop it.
    task automatic send_item(input t_in_item it);
        while (!calm && $urandom_range(0, 99) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_ready);
        board.take_input(it);
        @(negedge i_clk);
    endtask

    // len absorbs then a finish; byte_val < 0 means random bytes.
    // Finish carries a random byte, which the block must ignore.
    task automatic send_message(input int len, input int byte_val);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            it.operation = OP_ABSORB;
            it.data_byte = (byte_val < 0) ? 8'($urandom_range(0, 255)) : 8'(byte_val);
            send_item(it);
        end
        it.operation = OP_FINISH;
        it.data_byte = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    // Receiver: random ready, one long hold-off when the flood phase starts.
    initial begin : rx_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (flood_on && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
                i_ready <= 1'b0;
            end else if (calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Result monitor: sample at the rising edge, compare against the oldest due word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_word(o_out_item);
    end

    // Stimulus
    initial begin
        board     = new();
        calm      = 1'b0;
        flood_on  = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_item = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, single 0xFF byte, seven zero bytes (count byte
        // lands on the pad slot), one exact block (tail holds only pad and count).
        send_message(0, -1);
        send_message(1, 8'hFF);
        send_message(7, 8'h00);
        send_message(8, -1);

        // Random short messages, every fill level of the tail reachable
        repeat (4) send_message($urandom_range(0, 12), -1);

        // No-idle stretch: several blocks back to back
        calm = 1'b1;
        send_message(40, -1);
        repeat (2) send_message($urandom_range(0, 12), -1);
        calm = 1'b0;

        // Flood: short messages while the receiver holds off, so the job queue
        // backs up and the input stalls.
        flood_on = 1'b1;
        repeat (8) send_message($urandom_range(1, 4), -1);
        flood_on = 1'b0;

        repeat (3) send_message($urandom_range(0, 12), -1);
        i_valid <= 1'b0;

        // Drain, then allow for the finish latency to catch stray words
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
